/* hdl/assert_macros.svh */
// Assertion shorthands shared by the tracker's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define ASSERT_CLKD(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

/* hdl/lert_pkg.sv */
package lert_pkg;

    // Pixel value that counts as white.
    localparam logic [7:0] WHITE_LEVEL = 8'd255;

    // Field widths fixed by the interface.
    localparam int PIXEL_W    = 8;
    localparam int ROW_W      = 10;
    localparam int EDGE_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int HEIGHT_W   = 11;
    localparam int CUT_W      = 10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_CUT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_CUT   = 2'd2;

    // Configuration values after reset.
    localparam logic [HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 11'd120;
    localparam logic [CUT_W-1:0]    TOP_CUT_RST      = 10'd30;
    localparam logic [CUT_W-1:0]    BOTTOM_CUT_RST   = 10'd20;

    // Depth of the queue between the classifier and the edge tracker.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // Flags of one classified pixel word.
    typedef struct packed {
        logic frame_begin;
        logic row_end;
        logic in_window;
        logic close;
    } event_flags_t;

endpackage

/* hdl/lane_edge_run_tracker.sv */
// After its row-end pixel is taken, an edge word passes the four-word queue and
// the output register. One pixel word is taken per cycle while the queue has room;
// each row gives at most one edge word.
// A stalled output holds the queue only when the next word would report a row.
// Reset (rst_n low, asynchronous): registers return to height 120, top cut 30,
// bottom cut 20; run and edge state clear and the start-row search restarts.
module lane_edge_run_tracker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lert_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lert_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               pixel_valid,
    output logic                               pixel_ready,
    input  logic [lert_pkg::PIXEL_W-1:0]       pixel,
    input  logic [lert_pkg::ROW_W-1:0]         row_index,
    input  logic                               row_end,
    input  logic                               frame_begin,
    output logic                               edge_valid,
    input  logic                               edge_ready,
    output logic [lert_pkg::ROW_W-1:0]         edge_row,
    output logic [lert_pkg::EDGE_W-1:0]        left_edge,
    output logic [lert_pkg::EDGE_W-1:0]        right_edge,
    output logic                               start_row
);

    localparam int PW = $clog2(MAX_WIDTH);
    localparam int FW = $bits(lert_pkg::event_flags_t);
    localparam int QW = FW + 2 * PW + lert_pkg::ROW_W;

    logic                        push;
    logic                        pop;
    logic                        queue_full;
    logic                        queue_not_empty;
    lert_pkg::event_flags_t      front_flags;
    logic [PW-1:0]               front_begin;
    logic [PW-1:0]               front_end;
    logic [QW-1:0]               q_wdata;
    logic [QW-1:0]               q_rdata;
    lert_pkg::event_flags_t      back_flags;
    logic [PW-1:0]               back_begin;
    logic [PW-1:0]               back_end;
    logic [lert_pkg::ROW_W-1:0]  back_row;

    // Pixel classifier and configuration registers.
    lert_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PW         (PW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .row_index   (row_index),
        .row_end     (row_end),
        .frame_begin (frame_begin),
        .queue_full  (queue_full),
        .push        (push),
        .flags       (front_flags),
        .close_begin (front_begin),
        .close_end   (front_end)
    );

    // Pack and unpack the classified word around the queue.
    assign q_wdata    = {front_flags, front_begin, front_end, row_index};
    assign back_flags = lert_pkg::event_flags_t'(q_rdata[QW-1 -: FW]);
    assign back_begin = q_rdata[2*PW+lert_pkg::ROW_W-1 -: PW];
    assign back_end   = q_rdata[PW+lert_pkg::ROW_W-1 -: PW];
    assign back_row   = q_rdata[lert_pkg::ROW_W-1:0];

    lert_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     (q_wdata),
        .pop       (pop),
        .rdata     (q_rdata),
        .full      (queue_full),
        .not_empty (queue_not_empty)
    );

    // Edge tracker and output register.
    lert_back #(
        .PW (PW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (queue_not_empty),
        .flags       (back_flags),
        .close_begin (back_begin),
        .close_end   (back_end),
        .row_in      (back_row),
        .pop         (pop),
        .edge_valid  (edge_valid),
        .edge_ready  (edge_ready),
        .edge_row    (edge_row),
        .left_edge   (left_edge),
        .right_edge  (right_edge),
        .start_row   (start_row)
    );

endmodule

/* hdl/lert_front.sv */
`include "assert_macros.svh"

module lert_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PW         = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lert_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lert_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               pixel_valid,
    output logic                               pixel_ready,
    input  logic [lert_pkg::PIXEL_W-1:0]       pixel,
    input  logic [lert_pkg::ROW_W-1:0]         row_index,
    input  logic                               row_end,
    input  logic                               frame_begin,
    input  logic                               queue_full,
    output logic                               push,
    output lert_pkg::event_flags_t             flags,
    output logic [PW-1:0]                      close_begin,
    output logic [PW-1:0]                      close_end
);

    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int HB  = $clog2(MAX_HEIGHT + 1);
    localparam int HW  = (HB > 12) ? HB : 12;

    logic [lert_pkg::HEIGHT_W-1:0] image_height_reg;
    logic [lert_pkg::CUT_W-1:0]    top_cut_reg;
    logic [lert_pkg::CUT_W-1:0]    bottom_cut_reg;

    logic [CW-1:0] column_count_reg, column_count_next;
    logic          in_run_reg, in_run_next;
    logic [PW-1:0] run_begin_reg, run_begin_next;

    logic [CW-1:0] col;
    logic [PW-1:0] col_pos;
    logic          col_ok;
    logic          run_open;
    logic          white;
    logic          close_px;
    logic          close_row;
    logic [HW-1:0] height_clip;
    logic [HW-1:0] row_span;

    // The classifier moves as long as the queue has room.
    assign pixel_ready = !queue_full;
    assign push        = pixel_valid && pixel_ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_height_reg <= lert_pkg::IMAGE_HEIGHT_RST;
            top_cut_reg      <= lert_pkg::TOP_CUT_RST;
            bottom_cut_reg   <= lert_pkg::BOTTOM_CUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lert_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                lert_pkg::CFG_TOP_CUT:      top_cut_reg <= cfg_data[lert_pkg::CUT_W-1:0];
                lert_pkg::CFG_BOTTOM_CUT:   bottom_cut_reg <= cfg_data[lert_pkg::CUT_W-1:0];
                default:                    ;
            endcase
        end
    end

    // Row window test on the row number carried by this pixel.
    always_comb
    begin
        if (HW'(image_height_reg) < HW'(MAX_HEIGHT))
            height_clip = HW'(image_height_reg);
        else
            height_clip = HW'(MAX_HEIGHT);
        row_span = HW'(row_index) + HW'(bottom_cut_reg) + HW'(1);
    end

    // Run detection: start, close and row-end close of white runs.
    always_comb
    begin
        col      = frame_begin ? '0 : column_count_reg;
        run_open = frame_begin ? 1'b0 : in_run_reg;
        col_ok   = col < CW'(MAX_WIDTH);
        col_pos  = col[PW-1:0];
        white    = (pixel == lert_pkg::WHITE_LEVEL);

        in_run_next    = run_open;
        run_begin_next = run_begin_reg;
        close_px       = 1'b0;
        close_row      = 1'b0;
        close_end      = col_pos - PW'(1);

        if (col_ok)
        begin
            if (white && !run_open)
            begin
                in_run_next    = 1'b1;
                run_begin_next = col_pos;
            end
            else if (!white && run_open)
            begin
                close_px    = 1'b1;
                in_run_next = 1'b0;
            end
        end

        column_count_next = col_ok ? col + CW'(1) : col;

        if (row_end && in_run_next)
        begin
            close_row = 1'b1;
            close_end = col_ok ? col_pos : PW'(MAX_WIDTH - 1);
        end

        if (row_end)
        begin
            column_count_next = '0;
            in_run_next       = 1'b0;
        end

        close_begin       = run_begin_next;
        flags.frame_begin = frame_begin;
        flags.row_end     = row_end;
        flags.in_window   = (HW'(row_index) >= HW'(top_cut_reg)) && (row_span <= height_clip);
        flags.close       = close_px || close_row;
    end

    // Run state advances on every accepted pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            in_run_reg       <= 1'b0;
            run_begin_reg    <= '0;
        end
        else if (push)
        begin
            column_count_reg <= column_count_next;
            in_run_reg       <= in_run_next;
            run_begin_reg    <= run_begin_next;
        end
    end

    `ASSERT_CLKD(a_col_bound, clk, rst_n, column_count_reg <= CW'(MAX_WIDTH), "column count past limit")
    `ASSERT_CLKD(a_close_order, clk, rst_n, (push && flags.close) |-> (close_end >= close_begin), "run closed before it began")

endmodule

/* hdl/lert_queue.sv */
`include "assert_macros.svh"

module lert_queue #(
    parameter int WIDTH = 34
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             not_empty
);

    localparam int CNT_W = $clog2(lert_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]                 data_mem [lert_pkg::QUEUE_DEPTH];
    logic [lert_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [lert_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]                 count_reg;

    assign full      = (count_reg == CNT_W'(lert_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = data_mem[rd_ptr_reg];

    // Word storage.
    always_ff @(posedge clk)
    begin
        if (push)
            data_mem[wr_ptr_reg] <= wdata;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + lert_pkg::QUEUE_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + lert_pkg::QUEUE_PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    `ASSERT_CLKD(a_count_bound, clk, rst_n, count_reg <= CNT_W'(lert_pkg::QUEUE_DEPTH), "queue count past depth")
    `ASSERT_CLKD(a_no_overflow, clk, rst_n, push |-> !full, "write into a full queue")
    `ASSERT_CLKD(a_no_underflow, clk, rst_n, pop |-> not_empty, "read from an empty queue")

endmodule

/* hdl/lert_back.sv */
`include "assert_macros.svh"

module lert_back #(
    parameter int PW = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  lert_pkg::event_flags_t       flags,
    input  logic [PW-1:0]                close_begin,
    input  logic [PW-1:0]                close_end,
    input  logic [lert_pkg::ROW_W-1:0]   row_in,
    output logic                         pop,
    output logic                         edge_valid,
    input  logic                         edge_ready,
    output logic [lert_pkg::ROW_W-1:0]   edge_row,
    output logic [lert_pkg::EDGE_W-1:0]  left_edge,
    output logic [lert_pkg::EDGE_W-1:0]  right_edge,
    output logic                         start_row
);

    logic          seeking_reg, seeking_next;
    logic [PW-1:0] prev_left_reg, prev_left_next;
    logic [PW-1:0] prev_right_reg, prev_right_next;
    logic          any_run_reg, any_run_next;
    logic [PW-1:0] widest_b_reg, widest_b_next;
    logic [PW-1:0] widest_e_reg, widest_e_next;
    logic [PW-1:0] first_b_reg, first_b_next;
    logic [PW-1:0] last_e_reg, last_e_next;
    logic          lmf_reg, lmf_next;
    logic [PW-1:0] lmb_reg, lmb_next;
    logic          rmf_reg, rmf_next;
    logic [PW-1:0] rme_reg, rme_next;

    logic                        edge_valid_reg;
    logic [lert_pkg::ROW_W-1:0]  edge_row_reg;
    logic [PW-1:0]               left_reg;
    logic [PW-1:0]               right_reg;
    logic                        start_row_reg;

    logic          emit;
    logic          out_free;
    logic [PW-1:0] left_sel;
    logic [PW-1:0] right_sel;
    logic          start_sel;

    assign out_free = !edge_valid_reg || edge_ready;
    assign pop      = q_valid && (!emit || out_free);

    // Merge the word's run into the row summary and pick the edges.
    always_comb
    begin
        seeking_next    = flags.frame_begin ? 1'b1 : seeking_reg;
        prev_left_next  = prev_left_reg;
        prev_right_next = prev_right_reg;
        any_run_next    = flags.frame_begin ? 1'b0 : any_run_reg;
        widest_b_next   = flags.frame_begin ? '0 : widest_b_reg;
        widest_e_next   = flags.frame_begin ? '0 : widest_e_reg;
        first_b_next    = flags.frame_begin ? '0 : first_b_reg;
        last_e_next     = flags.frame_begin ? '0 : last_e_reg;
        lmf_next        = flags.frame_begin ? 1'b0 : lmf_reg;
        lmb_next        = flags.frame_begin ? '0 : lmb_reg;
        rmf_next        = flags.frame_begin ? 1'b0 : rmf_reg;
        rme_next        = flags.frame_begin ? '0 : rme_reg;

        if (flags.close)
        begin
            if (!any_run_next)
            begin
                first_b_next  = close_begin;
                widest_b_next = close_begin;
                widest_e_next = close_end;
            end
            else if ((close_end - close_begin) > (widest_e_next - widest_b_next))
            begin
                widest_b_next = close_begin;
                widest_e_next = close_end;
            end
            last_e_next = close_end;
            if (!lmf_next && prev_left_reg >= close_begin && prev_left_reg <= close_end)
            begin
                lmf_next = 1'b1;
                lmb_next = close_begin;
            end
            if (prev_right_reg >= close_begin && prev_right_reg <= close_end)
            begin
                rmf_next = 1'b1;
                rme_next = close_end;
            end
            any_run_next = 1'b1;
        end

        // Start row reports the widest run, later rows follow the last edges.
        if (seeking_next)
        begin
            left_sel  = widest_b_next;
            right_sel = widest_e_next;
        end
        else
        begin
            left_sel  = lmf_next ? lmb_next : first_b_next;
            right_sel = rmf_next ? rme_next : last_e_next;
        end

        // The start-row mark is taken before the search flag drops below.
        start_sel = seeking_next;

        emit = flags.row_end && any_run_next && flags.in_window;

        if (flags.row_end)
        begin
            if (emit)
            begin
                seeking_next    = 1'b0;
                prev_left_next  = left_sel;
                prev_right_next = right_sel;
            end
            any_run_next  = 1'b0;
            widest_b_next = '0;
            widest_e_next = '0;
            first_b_next  = '0;
            last_e_next   = '0;
            lmf_next      = 1'b0;
            lmb_next      = '0;
            rmf_next      = 1'b0;
            rme_next      = '0;
        end
    end

    // Tracking state advances on every word taken from the queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeking_reg    <= 1'b1;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            any_run_reg    <= 1'b0;
            widest_b_reg   <= '0;
            widest_e_reg   <= '0;
            first_b_reg    <= '0;
            last_e_reg     <= '0;
            lmf_reg        <= 1'b0;
            lmb_reg        <= '0;
            rmf_reg        <= 1'b0;
            rme_reg        <= '0;
        end
        else if (pop)
        begin
            seeking_reg    <= seeking_next;
            prev_left_reg  <= prev_left_next;
            prev_right_reg <= prev_right_next;
            any_run_reg    <= any_run_next;
            widest_b_reg   <= widest_b_next;
            widest_e_reg   <= widest_e_next;
            first_b_reg    <= first_b_next;
            last_e_reg     <= last_e_next;
            lmf_reg        <= lmf_next;
            lmb_reg        <= lmb_next;
            rmf_reg        <= rmf_next;
            rme_reg        <= rme_next;
        end
    end

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            edge_valid_reg <= 1'b0;
        else if (pop && emit)
            edge_valid_reg <= 1'b1;
        else if (edge_ready)
            edge_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            edge_row_reg  <= row_in;
            left_reg      <= left_sel;
            right_reg     <= right_sel;
            start_row_reg <= start_sel;
        end
    end

    assign edge_valid = edge_valid_reg;
    assign edge_row   = edge_row_reg;
    assign left_edge  = lert_pkg::EDGE_W'(left_reg);
    assign right_edge = lert_pkg::EDGE_W'(right_reg);
    assign start_row  = start_row_reg;

    `ASSERT_CLKD(a_emit_on_row_end, clk, rst_n, (pop && emit) |-> (flags.row_end && flags.in_window), "edge word outside a row end in the window")
    `ASSERT_CLKD(a_no_overwrite, clk, rst_n, (edge_valid_reg && !edge_ready) |=> edge_valid_reg, "pending edge word dropped")

endmodule

/* verif/tb_lane_edge_run_tracker.sv */
`timescale 1ns / 1ps

module tb_lane_edge_run_tracker;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [lert_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Cycles to let pass after the last edge word, covering the queue and output register.
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_NS     = 1000000;
    localparam int LONG_ROW     = 1030;

    // One edge word as the block reports it.
    typedef struct packed {
        logic [lert_pkg::ROW_W-1:0]  row;
        logic [lert_pkg::EDGE_W-1:0] left;
        logic [lert_pkg::EDGE_W-1:0] right;
        logic                        start;
    } edge_word_t;

    // One pixel word of the directed table, with a typed-in edge word where pinned.
    typedef struct {
        logic [lert_pkg::PIXEL_W-1:0] px;
        logic [lert_pkg::ROW_W-1:0]   row;
        logic                         rend;
        logic                         fbeg;
        bit                           pinned;
        edge_word_t                   want;
    } pixel_step_t;

    logic                            clk;
    logic                            rst_n       = 1'b0;
    logic                            cfg_we      = 1'b0;
    logic [lert_pkg::CFG_IDX_W-1:0]  cfg_index   = lert_pkg::CFG_IMAGE_HEIGHT;
    logic [lert_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
    logic                            pixel_valid = 1'b0;
    logic                            pixel_ready;
    logic [lert_pkg::PIXEL_W-1:0]    pixel       = '0;
    logic [lert_pkg::ROW_W-1:0]      row_index   = '0;
    logic                            row_end     = 1'b0;
    logic                            frame_begin = 1'b0;
    logic                            edge_valid;
    logic                            edge_ready  = 1'b0;
    logic [lert_pkg::ROW_W-1:0]      edge_row;
    logic [lert_pkg::EDGE_W-1:0]     left_edge;
    logic [lert_pkg::EDGE_W-1:0]     right_edge;
    logic                            start_row;

    // Edge words worked out by the tracker model, oldest first.
    edge_word_t edges_due[$];

    int pixels_sent;
    int edges_seen;
    int start_rows_seen;
    int mismatches;
    int send_calm;
    int sink_calm;

    // Window settings as the block should hold them.
    int win_height;
    int win_top;
    int win_bottom;

    // Tracker model state.
    int col_count;
    bit run_open;
    int run_from;
    bit hunting_start;
    int prior_left;
    int prior_right;
    bit row_has_run;
    int wide_from;
    int wide_to;
    int first_from;
    int last_to;
    bit left_hit;
    int left_from;
    bit right_hit;
    int right_to;

    // Drifting white band used to build track-like rows.
    int band_l = 2;
    int band_r = 5;

    // Directed words under the reset window, rows 30 to 99.
    pixel_step_t directed_rows [21] = '{
        // Bottom window row opening a frame: runs 0..1 and 3..5, the wider one wins.
        '{lert_pkg::WHITE_LEVEL, 10'd0,    1'b0, 1'b1, 1'b0, '0},
        '{lert_pkg::WHITE_LEVEL, 10'd1023, 1'b0, 1'b0, 1'b0, '0},
        '{8'd0,                  10'd0,    1'b0, 1'b0, 1'b0, '0},
        '{lert_pkg::WHITE_LEVEL, 10'd512,  1'b0, 1'b0, 1'b0, '0},
        '{lert_pkg::WHITE_LEVEL, 10'd0,    1'b0, 1'b0, 1'b0, '0},
        '{lert_pkg::WHITE_LEVEL, 10'd99,   1'b1, 1'b0, 1'b1, '{10'd99, 10'd3, 10'd5, 1'b1}},
        // Row just below the window.
        '{lert_pkg::WHITE_LEVEL, 10'd0,    1'b0, 1'b0, 1'b0, '0},
        '{lert_pkg::WHITE_LEVEL, 10'd100,  1'b1, 1'b0, 1'b0, '0},
        // Top window row: left edge follows, right edge falls back to the last run.
        '{8'd0,                  10'd0,    1'b0, 1'b0, 1'b0, '0},
        '{lert_pkg::WHITE_LEVEL, 10'd0,    1'b0, 1'b0, 1'b0, '0},
        '{8'd0,                  10'd0,    1'b0, 1'b0, 1'b0, '0},
        '{lert_pkg::WHITE_LEVEL, 10'd0,    1'b0, 1'b0, 1'b0, '0},
        '{8'd254,                10'd30,   1'b1, 1'b0, 1'b0, '0},
        // Row just above the window.
        '{lert_pkg::WHITE_LEVEL, 10'd29,   1'b1, 1'b0, 1'b0, '0},
        // Row with no white at all.
        '{8'd0,                  10'd0,    1'b0, 1'b0, 1'b0, '0},
        '{8'd128,                10'd0,    1'b0, 1'b0, 1'b0, '0},
        '{8'd254,                10'd50,   1'b1, 1'b0, 1'b0, '0},
        // New frame with two equal runs: the earlier one wins on the start row.
        '{lert_pkg::WHITE_LEVEL, 10'd0,    1'b0, 1'b1, 1'b0, '0},
        '{8'd0,                  10'd0,    1'b0, 1'b0, 1'b0, '0},
        '{lert_pkg::WHITE_LEVEL, 10'd60,   1'b1, 1'b0, 1'b1, '{10'd60, 10'd0, 10'd0, 1'b1}},
        // Highest row index, far outside the window.
        '{lert_pkg::WHITE_LEVEL, 10'd1023, 1'b1, 1'b0, 1'b0, '0}
    };

    lane_edge_run_tracker dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .row_index   (row_index),
        .row_end     (row_end),
        .frame_begin (frame_begin),
        .edge_valid  (edge_valid),
        .edge_ready  (edge_ready),
        .edge_row    (edge_row),
        .left_edge   (left_edge),
        .right_edge  (right_edge),
        .start_row   (start_row)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Clears everything the tracker keeps for the row in progress.
    function automatic void clear_row_state();
        col_count   = 0;
        run_open    = 1'b0;
        run_from    = 0;
        row_has_run = 1'b0;
        wide_from   = 0;
        wide_to     = 0;
        first_from  = 0;
        last_to     = 0;
        left_hit    = 1'b0;
        left_from   = 0;
        right_hit   = 1'b0;
        right_to    = 0;
    endfunction

    // Records a closed run b..e: widest, first, last, and matches with the last edges.
    function automatic void note_run(input int b, input int e);
        if (!row_has_run)
        begin
            first_from = b;
            wide_from  = b;
            wide_to    = e;
        end
        else if (e - b > wide_to - wide_from)
        begin
            wide_from = b;
            wide_to   = e;
        end
        last_to = e;
        if (!left_hit && prior_left >= b && prior_left <= e)
        begin
            left_hit  = 1'b1;
            left_from = b;
        end
        if (prior_right >= b && prior_right <= e)
        begin
            right_hit = 1'b1;
            right_to  = e;
        end
        row_has_run = 1'b1;
        run_open    = 1'b0;
    endfunction

    // Takes one accepted pixel word and queues the edge word it causes, if any.
    function automatic void track_pixel(input logic [lert_pkg::PIXEL_W-1:0] px,
                                        input logic [lert_pkg::ROW_W-1:0] row,
                                        input logic rend, input logic fbeg);
        int col;
        int lim;
        int lft;
        int rgt;
        bit col_taken;
        edge_word_t w;
        col_taken = 1'b0;
        if (fbeg)
        begin
            hunting_start = 1'b1;
            clear_row_state();
        end
        col = col_count;
        // Columns past the widest row are dropped, but row_end still closes the row.
        if (col < MAX_WIDTH)
        begin
            col_taken = 1'b1;
            if (px == lert_pkg::WHITE_LEVEL && !run_open)
            begin
                run_open = 1'b1;
                run_from = col;
            end
            else if (px != lert_pkg::WHITE_LEVEL && run_open)
                note_run(run_from, col - 1);
            col_count = col + 1;
        end
        if (!rend)
            return;
        if (run_open)
            note_run(run_from, col_taken ? col : MAX_WIDTH - 1);
        lim = (win_height < MAX_HEIGHT) ? win_height : MAX_HEIGHT;
        if (row_has_run && int'(row) >= win_top && int'(row) + win_bottom + 1 <= lim)
        begin
            if (hunting_start)
            begin
                lft = wide_from;
                rgt = wide_to;
            end
            else
            begin
                lft = left_hit ? left_from : first_from;
                rgt = right_hit ? right_to : last_to;
            end
            w.row   = row;
            w.left  = lft[lert_pkg::EDGE_W-1:0];
            w.right = rgt[lert_pkg::EDGE_W-1:0];
            w.start = hunting_start;
            edges_due.push_back(w);
            hunting_start = 1'b0;
            prior_left    = lft;
            prior_right   = rgt;
        end
        clear_row_state();
    endfunction

    // Draws a wait in cycles, with runs of back-to-back words now and then.
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // Offers one pixel word after a random gap and waits until it is taken.
    task automatic send_word(input logic [lert_pkg::PIXEL_W-1:0] px,
                             input logic [lert_pkg::ROW_W-1:0] row,
                             input logic rend, input logic fbeg);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= px;
        row_index   <= row;
        row_end     <= rend;
        frame_begin <= fbeg;
        do
            @(posedge clk);
        while (pixel_ready !== 1'b1);
        track_pixel(px, row, rend, fbeg);
        pixels_sent++;
    endtask

    // Writes all three window registers on back-to-back edges.
    task automatic program_window(input logic [lert_pkg::CFG_DATA_W-1:0] h,
                                  input logic [lert_pkg::CFG_DATA_W-1:0] t,
                                  input logic [lert_pkg::CFG_DATA_W-1:0] b);
        cfg_we    <= 1'b1;
        cfg_index <= lert_pkg::CFG_IMAGE_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_index <= lert_pkg::CFG_TOP_CUT;
        cfg_data  <= t;
        @(posedge clk);
        cfg_index <= lert_pkg::CFG_BOTTOM_CUT;
        cfg_data  <= b;
        @(posedge clk);
        cfg_we     <= 1'b0;
        win_height = int'(h[lert_pkg::HEIGHT_W-1:0]);
        win_top    = int'(t[lert_pkg::CUT_W-1:0]);
        win_bottom = int'(b[lert_pkg::CUT_W-1:0]);
    endtask

    // Lets the block drain: every due edge word out, then the pipeline latency.
    task automatic settle();
        pixel_valid <= 1'b0;
        while (edges_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Sends random rows, mostly track-like and inside the window, until the budget is spent.
    task automatic random_rows(input int budget);
        int first_count;
        int width;
        int style;
        int lo;
        int hi;
        int lim;
        int blob_l;
        int blob_r;
        int break_col;
        int c;
        bit fresh;
        bit white;
        logic [lert_pkg::ROW_W-1:0] row;
        first_count = pixels_sent;
        while (pixels_sent - first_count < budget)
        begin
            fresh = ($urandom_range(0, 7) == 0);
            width = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            lim   = (win_height < MAX_HEIGHT) ? win_height : MAX_HEIGHT;
            lo    = win_top;
            hi    = lim - win_bottom - 1;
            if (hi >= lo && $urandom_range(0, 4) != 0)
                row = lert_pkg::ROW_W'($urandom_range(hi, lo));
            else
                row = lert_pkg::ROW_W'($urandom_range(0, 1023));
            // Styles: 0-5 drifting band, 6-7 noise, 8 dark, 9 frame start mid-row.
            style = $urandom_range(0, 9);
            band_l = band_l + $urandom_range(0, 4) - 2;
            band_r = band_r + $urandom_range(0, 4) - 2;
            if (band_l < 0)
                band_l = 0;
            if (band_r > width - 1)
                band_r = width - 1;
            if (band_l > width - 1)
                band_l = width - 1;
            if (band_r < band_l)
                band_r = band_l;
            blob_l = width;
            blob_r = width;
            if ($urandom_range(0, 2) == 0)
            begin
                blob_l = $urandom_range(0, width - 1);
                blob_r = blob_l + $urandom_range(0, 3);
            end
            break_col = (width > 1) ? $urandom_range(1, width - 1) : 0;
            for (c = 0; c < width; c++)
            begin
                case (style)
                    6, 7:    white = ($urandom_range(0, 1) != 0);
                    8:       white = 1'b0;
                    9:       white = ($urandom_range(0, 1) != 0);
                    default: white = (c >= band_l && c <= band_r) || (c >= blob_l && c <= blob_r);
                endcase
                send_word(white ? lert_pkg::WHITE_LEVEL
                                : lert_pkg::PIXEL_W'($urandom_range(0, 254)),
                          (c == width - 1) ? row : lert_pkg::ROW_W'($urandom_range(0, 1023)),
                          c == width - 1,
                          (c == 0 && fresh) || (style == 9 && c == break_col && c != 0));
            end
        end
    endtask

    // Result side: random stalls, each edge word checked against the oldest one due.
    initial
    begin : edge_sink
        edge_word_t got;
        edge_word_t want;
        int gap;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = draw_wait(sink_calm);
            if (gap > 0)
            begin
                edge_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            edge_ready <= 1'b1;
            do
                @(posedge clk);
            while (edge_valid !== 1'b1);
            got = '{edge_row, left_edge, right_edge, start_row};
            edges_seen++;
            if (got.start)
                start_rows_seen++;
            if (edges_due.size() == 0)
            begin
                $display("%0t: edge word with none due: row %0d left %0d right %0d start %0b",
                         $time, got.row, got.left, got.right, got.start);
                mismatches++;
            end
            else
            begin
                want = edges_due.pop_front();
                if (got.row !== want.row)
                begin
                    $display("%0t: edge_row expected %0d, got %0d", $time, want.row, got.row);
                    mismatches++;
                end
                if (got.left !== want.left)
                begin
                    $display("%0t: left_edge expected %0d, got %0d", $time, want.left, got.left);
                    mismatches++;
                end
                if (got.right !== want.right)
                begin
                    $display("%0t: right_edge expected %0d, got %0d",
                             $time, want.right, got.right);
                    mismatches++;
                end
                if (got.start !== want.start)
                begin
                    $display("%0t: start_row expected %0b, got %0b",
                             $time, want.start, got.start);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus: directed table, then random rows under several window settings.
    initial
    begin : stimulus
        int due_before;
        int c;
        win_height    = int'(lert_pkg::IMAGE_HEIGHT_RST);
        win_top       = int'(lert_pkg::TOP_CUT_RST);
        win_bottom    = int'(lert_pkg::BOTTOM_CUT_RST);
        hunting_start = 1'b1;
        prior_left    = 0;
        prior_right   = 0;
        clear_row_state();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            due_before = edges_due.size();
            send_word(directed_rows[i].px, directed_rows[i].row,
                      directed_rows[i].rend, directed_rows[i].fbeg);
            // A pinned row is checked against the word typed into the table.
            if (directed_rows[i].pinned)
            begin
                if (edges_due.size() > due_before)
                    void'(edges_due.pop_back());
                edges_due.push_back(directed_rows[i].want);
            end
        end
        random_rows(110);

        // Whole image in the window.
        settle();
        program_window(11'd1024, 11'd0, 11'd0);
        random_rows(110);

        // Height above the limit, top cut with the spare data bit set: only row 1023 left.
        settle();
        program_window(11'h7FF, 11'h7FF, 11'd0);
        random_rows(90);

        // Zero height leaves no rows; the spare register index must be ignored.
        settle();
        program_window(11'd0, 11'd0, 11'd0);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_UNUSED;
        cfg_data  <= 11'h7FF;
        @(posedge clk);
        cfg_we    <= 1'b0;
        random_rows(50);

        // Largest bottom cut: only row 0 left.
        settle();
        program_window(11'd1024, 11'd0, 11'd1023);
        random_rows(90);

        // Ordinary window, one row longer than the widest the block keeps.
        settle();
        program_window(11'd200, 11'd10, 11'd5);
        for (c = 0; c < LONG_ROW; c++)
            send_word((c < 8 || (c >= 1000 && c != 1026)) ? lert_pkg::WHITE_LEVEL
                                                          : lert_pkg::PIXEL_W'(c % 200),
                      (c == LONG_ROW - 1) ? lert_pkg::ROW_W'(150)
                                          : lert_pkg::ROW_W'($urandom_range(0, 1023)),
                      c == LONG_ROW - 1, 1'b0);
        random_rows(110);

        settle();
        repeat (20) @(posedge clk);

        $display("Sent %0d pixel words under six window settings, one row past the width limit.",
                 pixels_sent);
        $display("Checked %0d edge words, %0d of them start rows; %0d mismatches.",
                 edges_seen, start_rows_seen, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog against a stuck handshake.
    initial
    begin
        #(LIMIT_NS);
        $display("%0t: run did not finish in time", $time);
        $display("Regression FAIL");
        $finish;
    end

endmodule
